// ----- design/sstq_pkg.sv -----
`default_nettype none

package sstq_pkg;

  // Fixed field widths of the channels
  localparam int unsigned TICK_W   = 63;
  localparam int unsigned THREAD_W = 8;
  localparam int unsigned DUR_W    = 32;
  localparam int unsigned PRIO_W   = 6;

  // Command codes
  localparam logic CMD_SLEEP = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Result kind
  typedef enum logic [1:0] {
    KIND_SLEEP = 2'd0,
    KIND_WOKEN = 2'd1,
    KIND_IDLE  = 2'd2
  } kind_e;

  // Sleep request status
  typedef enum logic [1:0] {
    STAT_QUEUED   = 2'd0,
    STAT_REJECTED = 2'd1,
    STAT_FULL     = 2'd2
  } status_e;

  // One result word from the controller to the output register
  typedef struct packed {
    kind_e               kind;
    status_e             status;
    logic [THREAD_W-1:0] woken_id;
    logic [TICK_W-1:0]   tick_count;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

// ----- design/sstq_if.sv -----
`default_nettype none

// Request channel: sleep or tick commands
interface sstq_in_if;
  logic              valid;
  logic              ready;
  logic              command;
  logic [7:0]        thread_id;
  logic signed [31:0] sleep_ticks;
  logic [5:0]        priority_req;

  modport source (output valid, command, thread_id, sleep_ticks, priority_req,
                  input ready);
  modport sink   (input valid, command, thread_id, sleep_ticks, priority_req,
                  output ready);
endinterface

// Result channel: sleep status and wake reports
interface sstq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [7:0]  woken_id;
  logic [62:0] tick_count;
  logic        last;

  modport source (output valid, kind, status, woken_id, tick_count, last,
                  input ready);
  modport sink   (input valid, kind, status, woken_id, tick_count, last,
                  output ready);
endinterface

`default_nettype wire

// ----- design/sorted_sleep_timer_queue_top.sv -----
`default_nettype none

// Sorted sleep-timer queue. A sleep word inserts its thread into a queue kept
// in one synchronous RAM, ordered by wake tick (counter + duration), higher
// priority first on equal ticks, arrival order otherwise; it returns one status
// word. A tick word advances the 63-bit counter and returns one word per woken
// thread from the front of the queue (last marks the final one), or a single
// no-wake word. Items are handled one at a time. A sleep item walks the queue
// from the tail to insert, one RAM read and one shifted write per cycle. A
// tick item makes one RAM read per entry examined and waits while the
// result side stalls. The output register lets the next item start while
// the last result word still waits. The RAM needs no clearing after reset.
module sorted_sleep_timer_queue_top
  import sstq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sstq_in_if.sink     in_i,
  sstq_out_if.source  out_o
);

  localparam int unsigned IdW  = (ID_BITS < THREAD_W) ? ID_BITS : THREAD_W;
  localparam int unsigned EntW = TICK_W + PRIO_W + IdW;
  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);

  logic            res_valid;
  logic            res_ready;
  res_t            res;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [EntW-1:0] mem_wdata;
  logic [IdxW-1:0] mem_raddr;
  logic [EntW-1:0] mem_rdata;
  logic            out_valid_q;
  res_t            out_res_q;

  sstq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  sstq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EntW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: loads when empty or being drained
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_res_q.kind;
  assign out_o.status     = out_res_q.status;
  assign out_o.woken_id   = out_res_q.woken_id;
  assign out_o.tick_count = out_res_q.tick_count;
  assign out_o.last       = out_res_q.last;

endmodule

`default_nettype wire

// ----- design/sstq_mem.sv -----
`default_nettype none

module sstq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 77
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/sstq_ctrl.sv -----
`default_nettype none

module sstq_ctrl
  import sstq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8,
  localparam int unsigned IdW  = (ID_BITS < THREAD_W) ? ID_BITS : THREAD_W,
  localparam int unsigned EntW = TICK_W + PRIO_W + IdW,
  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  sstq_in_if.sink              in_i,
  output      logic            res_valid_o,
  input  wire logic            res_ready_i,
  output      res_t            res_o,
  output      logic            mem_we_o,
  output      logic [IdxW-1:0] mem_waddr_o,
  output      logic [EntW-1:0] mem_wdata_o,
  output      logic [IdxW-1:0] mem_raddr_o,
  input  wire logic [EntW-1:0] mem_rdata_i
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW = IdxW + 1;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_INS      = 5'b00010,
    S_INS_LAST = 5'b00100,
    S_TICK     = 5'b01000,
    S_EMIT     = 5'b10000
  } state_e;

  // Logical queue offset to physical slot, ring of QUEUE_DEPTH entries
  function automatic logic [IdxW-1:0] phys(input logic [IdxW-1:0] base,
                                           input logic [IdxW-1:0] off);
    logic [SumW-1:0] s;
    s = SumW'(base) + SumW'(off);
    if (s >= SumW'(QUEUE_DEPTH)) begin
      s = s - SumW'(QUEUE_DEPTH);
    end
    return s[IdxW-1:0];
  endfunction

  state_e              state_q, state_d;
  logic [TICK_W-1:0]   counter_q, counter_d;
  logic [IdxW-1:0]     head_q, head_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [TICK_W-1:0]   new_wake_q, new_wake_d;
  logic [PRIO_W-1:0]   new_prio_q, new_prio_d;
  logic [IdW-1:0]      new_id_q, new_id_d;
  logic                pend_q, pend_d;
  logic [IdW-1:0]      pend_id_q, pend_id_d;
  kind_e               emit_kind_q, emit_kind_d;
  status_e             emit_status_q, emit_status_d;

  logic [TICK_W-1:0]   e_wake;
  logic [PRIO_W-1:0]   e_prio;
  logic [IdW-1:0]      e_id;
  logic                goes_before;
  logic                e_due;
  logic                nonpos;
  logic [TICK_W-1:0]   in_wake;

  // Fields of the entry read last cycle
  assign e_wake = mem_rdata_i[EntW-1 -: TICK_W];
  assign e_prio = mem_rdata_i[PRIO_W+IdW-1 -: PRIO_W];
  assign e_id   = mem_rdata_i[IdW-1:0];

  assign goes_before = (new_wake_q < e_wake) ||
                       ((new_wake_q == e_wake) && (new_prio_q > e_prio));
  assign e_due       = (e_wake <= counter_q);

  assign nonpos  = in_i.sleep_ticks[DUR_W-1] || (in_i.sleep_ticks == '0);
  assign in_wake = counter_q + TICK_W'(unsigned'(in_i.sleep_ticks));

  assign in_i.ready = (state_q == S_IDLE);

  // Sequencer: insert walks from the tail, tick walks from the head
  always_comb begin
    state_d       = state_q;
    counter_d     = counter_q;
    head_d        = head_q;
    count_d       = count_q;
    idx_d         = idx_q;
    new_wake_d    = new_wake_q;
    new_prio_d    = new_prio_q;
    new_id_d      = new_id_q;
    pend_d        = pend_q;
    pend_id_d     = pend_id_q;
    emit_kind_d   = emit_kind_q;
    emit_status_d = emit_status_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = head_q;
    mem_wdata_o   = {new_wake_q, new_prio_q, new_id_q};
    mem_raddr_o   = head_q;
    res_valid_o   = 1'b0;
    res_o.kind       = KIND_WOKEN;
    res_o.status     = STAT_QUEUED;
    res_o.woken_id   = THREAD_W'(pend_id_q);
    res_o.tick_count = counter_q;
    res_o.last       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          emit_status_d = STAT_QUEUED;
          if (in_i.command == CMD_TICK) begin
            counter_d = counter_q + TICK_W'(1);
            pend_d    = 1'b0;
            if (count_q == '0) begin
              emit_kind_d = KIND_IDLE;
              state_d     = S_EMIT;
            end else begin
              emit_kind_d = KIND_WOKEN;
              state_d     = S_TICK;
            end
          end else begin
            emit_kind_d = KIND_SLEEP;
            new_wake_d  = in_wake;
            new_prio_d  = in_i.priority_req;
            new_id_d    = in_i.thread_id[IdW-1:0];
            if (nonpos) begin
              emit_status_d = STAT_REJECTED;
              state_d       = S_EMIT;
            end else if (count_q == CntW'(QUEUE_DEPTH)) begin
              emit_status_d = STAT_FULL;
              state_d       = S_EMIT;
            end else if (count_q == '0) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = head_q;
              mem_wdata_o = {in_wake, in_i.priority_req, in_i.thread_id[IdW-1:0]};
              count_d     = count_q + CntW'(1);
              state_d     = S_EMIT;
            end else begin
              idx_d       = IdxW'(count_q - CntW'(1));
              mem_raddr_o = phys(head_q, IdxW'(count_q - CntW'(1)));
              state_d     = S_INS;
            end
          end
        end
      end

      S_INS: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = phys(head_q, idx_q + IdxW'(1));
        if (goes_before) begin
          // shift this entry up one slot
          mem_wdata_o = mem_rdata_i;
          if (idx_q == '0) begin
            state_d = S_INS_LAST;
          end else begin
            idx_d       = idx_q - IdxW'(1);
            mem_raddr_o = phys(head_q, idx_q - IdxW'(1));
          end
        end else begin
          count_d = count_q + CntW'(1);
          state_d = S_EMIT;
        end
      end

      S_INS_LAST: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = head_q;
        count_d     = count_q + CntW'(1);
        state_d     = S_EMIT;
      end

      S_TICK: begin
        // a due entry is held one step so that last can be known
        if (e_due) begin
          if (pend_q) begin
            res_valid_o = 1'b1;
          end
          if (!pend_q || res_ready_i) begin
            pend_d    = 1'b1;
            pend_id_d = e_id;
            head_d    = phys(head_q, IdxW'(1));
            count_d   = count_q - CntW'(1);
            if (count_q == CntW'(1)) begin
              state_d = S_EMIT;
            end else begin
              mem_raddr_o = phys(head_q, IdxW'(1));
            end
          end
        end else begin
          emit_kind_d = pend_q ? KIND_WOKEN : KIND_IDLE;
          state_d     = S_EMIT;
        end
      end

      S_EMIT: begin
        res_valid_o  = 1'b1;
        res_o.kind   = emit_kind_q;
        res_o.status = emit_status_q;
        res_o.woken_id = (emit_kind_q == KIND_WOKEN) ? THREAD_W'(pend_id_q) : '0;
        res_o.last   = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      counter_q <= '0;
      head_q    <= '0;
      count_q   <= '0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      counter_q <= counter_d;
      head_q    <= head_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
    end
  end

  // Work registers, no reset needed
  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    new_wake_q    <= new_wake_d;
    new_prio_q    <= new_prio_d;
    new_id_q      <= new_id_d;
    pend_id_q     <= pend_id_d;
    emit_kind_q   <= emit_kind_d;
    emit_status_q <= emit_status_d;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_shift_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && (state_q == S_INS)) |-> (mem_waddr_o != mem_raddr_o))
    else $error("shift writes the slot being read");

  a_mid_is_woken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |-> (res_o.kind == KIND_WOKEN))
    else $error("non-final result is not a wake report");

  a_tick_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.command == CMD_TICK))
      |=> (counter_q == $past(counter_q) + TICK_W'(1)))
    else $error("tick did not advance counter");

  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !res_valid_o)
    else $error("result while idle");

endmodule

`default_nettype wire

// ----- dv/sorted_sleep_timer_queue_top_test.sv -----
`timescale 1ns / 100ps

module sorted_sleep_timer_queue_top_test
  import sstq_pkg::*;
();

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 40;

  // One sleeping thread as the predictor keeps it
  typedef struct packed {
    logic [TICK_W-1:0]   wake;
    logic [PRIO_W-1:0]   prio;
    logic [THREAD_W-1:0] id;
  } sleeper_t;

  // One row of the directed script; the result is typed in where obvious
  typedef struct packed {
    logic                    cmd;
    logic [THREAD_W-1:0]     id;
    logic signed [DUR_W-1:0] dur;
    logic [PRIO_W-1:0]       prio;
    bit                      typed;
    kind_e                   kind;
    status_e                 status;
    logic [TICK_W-1:0]       tick;
  } script_row_t;

  logic clk_i;
  logic rst_ni;

  sstq_in_if  req_if ();
  sstq_out_if rsp_if ();

  sorted_sleep_timer_queue_top #(
    .QUEUE_DEPTH(SLOTS),
    .ID_BITS    (THREAD_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  // Predictor state
  logic [TICK_W-1:0] model_tick;
  sleeper_t          sleepers[$];
  res_t              fresh_q[$];
  res_t              awaited_q[$];

  int unsigned mismatches;
  bit          tx_rush;
  bit          rx_rush;
  bit          hold_req;

  script_row_t script [18] = '{
    '{CMD_TICK,  8'h00, 32'sd0,          6'd0,  1'b1, KIND_IDLE,  STAT_QUEUED,   63'd1},
    '{CMD_SLEEP, 8'h01, 32'sd0,          6'd5,  1'b1, KIND_SLEEP, STAT_REJECTED, 63'd1},
    '{CMD_SLEEP, 8'h02, 32'sh8000_0000,  6'd63, 1'b1, KIND_SLEEP, STAT_REJECTED, 63'd1},
    '{CMD_SLEEP, 8'h03, -32'sd1,         6'd0,  1'b1, KIND_SLEEP, STAT_REJECTED, 63'd1},
    '{CMD_SLEEP, 8'hff, 32'sd3,          6'd63, 1'b1, KIND_SLEEP, STAT_QUEUED,   63'd1},
    '{CMD_SLEEP, 8'h00, 32'sd3,          6'd0,  1'b1, KIND_SLEEP, STAT_QUEUED,   63'd1},
    '{CMD_SLEEP, 8'h55, 32'sd3,          6'd63, 1'b0, KIND_SLEEP, STAT_QUEUED,   63'd0},
    '{CMD_SLEEP, 8'haa, 32'sd1,          6'd10, 1'b0, KIND_SLEEP, STAT_QUEUED,   63'd0},
    '{CMD_SLEEP, 8'h07, 32'sh7fff_ffff,  6'd32, 1'b1, KIND_SLEEP, STAT_QUEUED,   63'd1},
    '{CMD_SLEEP, 8'h09, 32'sd2,          6'd1,  1'b0, KIND_SLEEP, STAT_QUEUED,   63'd0},
    '{CMD_SLEEP, 8'h09, 32'sd2,          6'd1,  1'b0, KIND_SLEEP, STAT_QUEUED,   63'd0},
    '{CMD_TICK,  8'h00, 32'sd0,          6'd0,  1'b0, KIND_SLEEP, STAT_QUEUED,   63'd0},
    '{CMD_TICK,  8'h00, 32'sd0,          6'd0,  1'b0, KIND_SLEEP, STAT_QUEUED,   63'd0},
    '{CMD_TICK,  8'h00, 32'sd0,          6'd0,  1'b0, KIND_SLEEP, STAT_QUEUED,   63'd0},
    '{CMD_TICK,  8'h00, 32'sd0,          6'd0,  1'b0, KIND_SLEEP, STAT_QUEUED,   63'd0},
    '{CMD_SLEEP, 8'h81, 32'sd1,          6'd0,  1'b0, KIND_SLEEP, STAT_QUEUED,   63'd0},
    '{CMD_SLEEP, 8'h42, 32'sd1,          6'd63, 1'b0, KIND_SLEEP, STAT_QUEUED,   63'd0},
    '{CMD_TICK,  8'h00, 32'sd0,          6'd0,  1'b0, KIND_SLEEP, STAT_QUEUED,   63'd0}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Predict the result words of one accepted word into fresh_q
  task automatic predict_word(input logic cmd, input logic [THREAD_W-1:0] id,
                              input logic signed [DUR_W-1:0] dur,
                              input logic [PRIO_W-1:0] prio);
    int                due;
    int                pos;
    logic [TICK_W-1:0] wake;
    sleeper_t          s;
    fresh_q.delete();
    if (cmd == CMD_TICK) begin
      model_tick = model_tick + 1'b1;
      due = 0;
      while (due < sleepers.size() && sleepers[due].wake <= model_tick) due++;
      if (due == 0) begin
        fresh_q.push_back(res_t'{KIND_IDLE, STAT_QUEUED, 8'd0, model_tick, 1'b1});
      end else begin
        for (int k = 0; k < due; k++) begin
          fresh_q.push_back(res_t'{KIND_WOKEN, STAT_QUEUED, sleepers[0].id, model_tick,
                                   (k == due - 1)});
          void'(sleepers.pop_front());
        end
      end
    end else if (dur <= 0) begin
      fresh_q.push_back(res_t'{KIND_SLEEP, STAT_REJECTED, 8'd0, model_tick, 1'b1});
    end else if (sleepers.size() >= SLOTS) begin
      fresh_q.push_back(res_t'{KIND_SLEEP, STAT_FULL, 8'd0, model_tick, 1'b1});
    end else begin
      // Sorted insert: earlier wake first, then higher priority, then arrival
      wake = model_tick + {31'd0, dur};
      pos  = sleepers.size();
      for (int i = 0; i < sleepers.size(); i++) begin
        if (wake < sleepers[i].wake ||
            (wake == sleepers[i].wake && prio > sleepers[i].prio)) begin
          pos = i;
          break;
        end
      end
      s = '{wake, prio, id};
      sleepers.insert(pos, s);
      fresh_q.push_back(res_t'{KIND_SLEEP, STAT_QUEUED, 8'd0, model_tick, 1'b1});
    end
  endtask

  // Offer one word after a random gap, then record what it should produce
  task automatic send_word(input logic cmd, input logic [THREAD_W-1:0] id,
                           input logic signed [DUR_W-1:0] dur,
                           input logic [PRIO_W-1:0] prio,
                           input bit typed, input res_t typed_res);
    int unsigned gap;
    gap = tx_rush ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.command      <= cmd;
    req_if.thread_id    <= id;
    req_if.sleep_ticks  <= dur;
    req_if.priority_req <= prio;
    req_if.valid        <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    predict_word(cmd, id, dur, prio);
    if (typed) awaited_q.push_back(typed_res);
    else foreach (fresh_q[i]) awaited_q.push_back(fresh_q[i]);
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Result side: random stalls, one long hold-off on request, checking
  initial begin
    res_t want;
    int unsigned stall;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      stall = rx_rush ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
      if (awaited_q.size() == 0) begin
        $error("result word with nothing awaited: kind %0d, id 0x%0h, tick %0d",
               rsp_if.kind, rsp_if.woken_id, rsp_if.tick_count);
        mismatches++;
      end else begin
        want = awaited_q.pop_front();
        check_field("kind", want.kind, rsp_if.kind);
        check_field("status", want.status, rsp_if.status);
        check_field("woken_id", want.woken_id, rsp_if.woken_id);
        check_field("tick_count", want.tick_count, rsp_if.tick_count);
        check_field("last", want.last, rsp_if.last);
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned r;
    int unsigned pace;
    int unsigned burst_dur;
    int unsigned sent;
    logic signed [DUR_W-1:0] dur;
    rst_ni                = 1'b0;
    req_if.valid          = 1'b0;
    req_if.command        = CMD_SLEEP;
    req_if.thread_id      = '0;
    req_if.sleep_ticks    = '0;
    req_if.priority_req   = '0;
    model_tick            = '0;
    mismatches            = 0;
    tx_rush               = 1'b0;
    rx_rush               = 1'b0;
    hold_req              = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed script
    foreach (script[i]) begin
      send_word(script[i].cmd, script[i].id, script[i].dur, script[i].prio, script[i].typed,
                res_t'{script[i].kind, script[i].status, 8'd0, script[i].tick, 1'b1});
    end

    // Random rounds: even rounds open with a burst on one wake tick that fills the queue, then mixed traffic
    for (int round = 0; round < 8; round++) begin
      pace    = $urandom_range(0, 5);
      tx_rush = (pace == 1 || pace == 3);
      rx_rush = (pace == 2 || pace == 3);
      if (round == 2 || round == 5) hold_req = 1'b1;
      sent = 0;
      if (round % 2 == 0) begin
        burst_dur = $urandom_range(1, 6);
        repeat (18) begin
          send_word(CMD_SLEEP, 8'($urandom), DUR_W'(burst_dur), 6'($urandom_range(0, 3)),
                    1'b0, '0);
          sent++;
        end
        repeat (burst_dur) begin
          send_word(CMD_TICK, 8'($urandom), DUR_W'($urandom), 6'($urandom), 1'b0, '0);
          sent++;
        end
      end
      while (sent < 52) begin
        r = $urandom_range(0, 99);
        if (r < 48) begin
          send_word(CMD_TICK, 8'($urandom), DUR_W'($urandom), 6'($urandom), 1'b0, '0);
        end else begin
          if (r < 88) dur = DUR_W'($urandom_range(1, 24));
          else if (r < 95) dur = $urandom | 32'h8000_0000;
          else if (r < 99) dur = 32'sd0;
          else dur = $urandom & 32'h7fff_ffff;
          send_word(CMD_SLEEP, 8'($urandom), dur, 6'($urandom), 1'b0, '0);
        end
        sent++;
      end
    end

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
